// File: rtl/core/swmf_pkg.sv
// Shared constants and types of the sliding window median filter.
package swmf_pkg;

    // Parameter defaults
    localparam int MAX_WINDOW_DEF   = 15;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Configuration port
    localparam int WINDOW_SIZE_W = 4;
    localparam int FIELD_SEL_W   = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_SELECT = 2'd1;

    localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RESET = 4'd3;

    // Field select codes
    localparam logic [FIELD_SEL_W-1:0] FIELD_VELOCITY = 2'd0;
    localparam logic [FIELD_SEL_W-1:0] FIELD_POWER    = 2'd1;
    localparam logic [FIELD_SEL_W-1:0] FIELD_WIDTH    = 2'd2;
    localparam logic [FIELD_SEL_W-1:0] FIELD_NONE     = 2'd3;

    // Status handed from one sorting cell to the next
    typedef struct packed {
        logic valid;  // cell holds a sample
        logic above;  // held sample is greater than the one being inserted
    } t_cell_flags;

endpackage

// File: rtl/core/sliding_window_median_filter.sv
// Top level of the sliding window median filter: history, control and output stage.
//
// Cells leave in order, W-1-W/2 inputs behind the input, where W is the window
// size (0 counts as 1, sizes above MAX_WINDOW count as MAX_WINDOW). A cell that
// gets the median first has the window samples enter the sorting row of
// MAX_WINDOW cells, one sample per cycle, and is then loaded into the output
// register, later while the output is stalled. A passed cell goes straight to
// the output register. A last input flushes up to W-W/2 cells, one per cycle
// while the output is not stalled. While a result waits in the output register
// the next input is still taken.
module sliding_window_median_filter import swmf_pkg::*; #(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic        [CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_velocity_in,
    input  logic signed [SAMPLE_WIDTH-1:0] i_power_in,
    input  logic signed [SAMPLE_WIDTH-1:0] i_width_in,
    input  logic                           i_last_item,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_velocity_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_power_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_width_out,
    output logic                           o_last_out
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (WIN_W > WINDOW_SIZE_W) ? WIN_W : WINDOW_SIZE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // Configuration registers
    logic [WINDOW_SIZE_W-1:0] r_window_size;
    logic [FIELD_SEL_W-1:0]   r_field_select;

    // Control registers
    logic [1:0]       r_state,  n_state;
    logic [IDX_W-1:0] r_seen,   n_seen;
    logic [IDX_W-1:0] r_feed,   n_feed;
    logic [IDX_W-1:0] r_age,    n_age;
    logic [IDX_W-1:0] r_mid,    n_mid;
    logic [WIN_W-1:0] r_win,    n_win;
    logic             r_filt,   n_filt;
    logic             r_flush,  n_flush;
    logic             r_out_valid, n_out_valid;

    // History shift line, newest first
    logic signed [SAMPLE_WIDTH-1:0] r_hist_vel [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] r_hist_pow [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] r_hist_wid [MAX_WINDOW];

    // Output payload
    logic signed [SAMPLE_WIDTH-1:0] r_out_vel;
    logic signed [SAMPLE_WIDTH-1:0] r_out_pow;
    logic signed [SAMPLE_WIDTH-1:0] r_out_wid;
    logic                           r_out_last;

    logic                           w_in_accept;
    logic                           w_load;
    logic        [CMP_W-1:0]        w_ws_ext;
    logic        [WIN_W-1:0]        w_win;
    logic        [WIN_W-1:0]        w_win_m1;
    logic        [WIN_W-1:0]        w_half;
    logic        [WIN_W-1:0]        w_delay;
    logic        [IDX_W-1:0]        w_delay_idx;
    logic        [IDX_W-1:0]        w_seen_c;
    logic        [IDX_W-1:0]        w_first;
    logic                           w_full;
    logic                           w_emit_any;
    logic                           w_filt;
    logic        [IDX_W-1:0]        w_rd_idx;
    logic signed [SAMPLE_WIDTH-1:0] w_rd_vel;
    logic signed [SAMPLE_WIDTH-1:0] w_rd_pow;
    logic signed [SAMPLE_WIDTH-1:0] w_rd_wid;
    logic signed [SAMPLE_WIDTH-1:0] w_feed_sample;
    logic signed [SAMPLE_WIDTH-1:0] w_median;

    assign w_in_accept = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_load      = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);

    // Take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size  <= WINDOW_SIZE_RESET;
            r_field_select <= FIELD_VELOCITY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_SIZE:  r_window_size  <= i_cfg_data[WINDOW_SIZE_W-1:0];
                REG_FIELD_SELECT: r_field_select <= i_cfg_data[FIELD_SEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the window and derive half width, delay and clamped count
    always_comb begin
        w_ws_ext = CMP_W'(r_window_size);
        if (r_window_size == '0) begin
            w_win = WIN_W'(1);
        end else if (w_ws_ext > CMP_W'(MAX_WINDOW)) begin
            w_win = WIN_W'(MAX_WINDOW);
        end else begin
            w_win = w_ws_ext[WIN_W-1:0];
        end
        w_win_m1    = w_win - WIN_W'(1);
        w_half      = w_win >> 1;
        w_delay     = w_win_m1 - w_half;
        w_delay_idx = w_delay[IDX_W-1:0];
        if (WIN_W'(r_seen) > w_win_m1) begin
            w_seen_c = w_win_m1[IDX_W-1:0];
        end else begin
            w_seen_c = r_seen;
        end
        w_full = (WIN_W'(w_seen_c) == w_win_m1);
        if (i_last_item) begin
            w_first    = (w_seen_c < w_delay_idx) ? w_seen_c : w_delay_idx;
            w_emit_any = 1'b1;
            w_filt     = (w_first == w_delay_idx) && w_full && w_win[0];
        end else begin
            w_first    = w_delay_idx;
            w_emit_any = (w_seen_c >= w_delay_idx);
            w_filt     = w_full;
        end
        if (r_field_select == FIELD_NONE) begin
            w_filt = 1'b0;
        end
    end

    // Shift the history on each accepted beat
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            for (int j = MAX_WINDOW - 1; j > 0; j--) begin
                r_hist_vel[j] <= r_hist_vel[j-1];
                r_hist_pow[j] <= r_hist_pow[j-1];
                r_hist_wid[j] <= r_hist_wid[j-1];
            end
            r_hist_vel[0] <= i_velocity_in;
            r_hist_pow[0] <= i_power_in;
            r_hist_wid[0] <= i_width_in;
        end
    end

    // Read the history at the feed position or the emitted age
    assign w_rd_idx = (r_state == ST_SORT) ? r_feed : r_age;
    assign w_rd_vel = r_hist_vel[w_rd_idx];
    assign w_rd_pow = r_hist_pow[w_rd_idx];
    assign w_rd_wid = r_hist_wid[w_rd_idx];

    always_comb begin
        case (r_field_select)
            FIELD_VELOCITY: w_feed_sample = w_rd_vel;
            FIELD_POWER:    w_feed_sample = w_rd_pow;
            default:        w_feed_sample = w_rd_wid;
        endcase
    end

    swmf_sorter #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_sorter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_in_accept),
        .i_insert (r_state == ST_SORT),
        .i_sample (w_feed_sample),
        .i_mid_idx(r_mid),
        .o_median (w_median)
    );

    // Sequence accept, sort and emit
    always_comb begin
        n_state     = r_state;
        n_seen      = r_seen;
        n_feed      = r_feed;
        n_age       = r_age;
        n_mid       = r_mid;
        n_win       = r_win;
        n_filt      = r_filt;
        n_flush     = r_flush;
        n_out_valid = w_load ? 1'b1 : (i_out_stall ? r_out_valid : 1'b0);
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    if (i_last_item) begin
                        n_seen = '0;
                    end else if (WIN_W'(w_seen_c) + WIN_W'(1) > w_win_m1) begin
                        n_seen = w_win_m1[IDX_W-1:0];
                    end else begin
                        n_seen = w_seen_c + IDX_W'(1);
                    end
                    n_feed  = '0;
                    n_age   = w_first;
                    n_mid   = w_half[IDX_W-1:0];
                    n_win   = w_win;
                    n_filt  = w_filt;
                    n_flush = i_last_item;
                    if (w_filt) begin
                        n_state = ST_SORT;
                    end else if (w_emit_any) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_SORT: begin
                if (WIN_W'(r_feed) == r_win - WIN_W'(1)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_feed = r_feed + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_filt = 1'b0;
                    if (r_flush && (r_age != '0)) begin
                        n_age = r_age - IDX_W'(1);
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seen      <= '0;
            r_feed      <= '0;
            r_age       <= '0;
            r_mid       <= '0;
            r_win       <= '0;
            r_filt      <= 1'b0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_feed      <= n_feed;
            r_age       <= n_age;
            r_mid       <= n_mid;
            r_win       <= n_win;
            r_filt      <= n_filt;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
        end
    end

    // Load the output beat, replacing the selected field by the median
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_vel  <= (r_filt && (r_field_select == FIELD_VELOCITY)) ? w_median : w_rd_vel;
            r_out_pow  <= (r_filt && (r_field_select == FIELD_POWER))    ? w_median : w_rd_pow;
            r_out_wid  <= (r_filt && (r_field_select == FIELD_WIDTH))    ? w_median : w_rd_wid;
            r_out_last <= r_flush && (r_age == '0);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_velocity_out = r_out_vel;
    assign o_power_out    = r_out_pow;
    assign o_width_out    = r_out_wid;
    assign o_last_out     = r_out_last;

`ifndef SYNTHESIS
    // The feed position stays inside the window while sorting
    a_feed_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SORT) |-> (WIN_W'(r_feed) < r_win))
        else $error("sort feed beyond window");

    // A median is only emitted after a sorting pass
    a_filt_after_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && r_filt) |->
        ($past(r_state) == ST_SORT || $past(r_state) == ST_EMIT))
        else $error("median emitted without sorting");

    // Loading the final flushed cell returns the block to idle
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_flush && r_age == '0) |=> (r_state == ST_IDLE && o_last_out))
        else $error("last beat did not end the item");

    // The emitted age never reaches the window size
    a_age_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (WIN_W'(r_age) < r_win))
        else $error("emit age beyond window");
`endif

endmodule

// File: rtl/core/swmf_sort_cell.sv
// One cell of the insertion sorting row: holds one sample of the sorted window.
module swmf_sort_cell import swmf_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_insert,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] i_prev_value,
    input  t_cell_flags                    i_prev_flags,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output t_cell_flags                    o_flags
);

    logic                           r_valid;
    logic                           n_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic signed [SAMPLE_WIDTH-1:0] n_value;
    logic                           w_above;

    // Compare the held sample against the one being inserted
    assign w_above = r_valid && (r_value > i_sample);

    // Keep a held sample not greater than the new one, else take the lower neighbor's or the new one
    always_comb begin
        if (r_valid && !w_above) begin
            n_value = r_value;
        end else if (i_prev_flags.above) begin
            n_value = i_prev_value;
        end else begin
            n_value = i_sample;
        end
        n_valid = r_valid | i_prev_flags.valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_insert) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_insert) begin
            r_value <= n_value;
        end
    end

    assign o_value       = r_value;
    assign o_flags.valid = r_valid;
    assign o_flags.above = w_above;

endmodule

// File: rtl/core/swmf_sorter.sv
// Cell row that keeps the window sorted ascending, one insert a cycle on i_insert.
module swmf_sorter import swmf_pkg::*; #(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int IDX_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_insert,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic        [IDX_W-1:0]        i_mid_idx,
    output logic signed [SAMPLE_WIDTH-1:0] o_median
);

    logic signed [SAMPLE_WIDTH-1:0] w_value [MAX_WINDOW];
    t_cell_flags                    w_flags [MAX_WINDOW];

    // Chain the cells; the first one sees a full, lower neighbor
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] w_prev_value;
        t_cell_flags                    w_prev_flags;

        if (g == 0) begin : g_head
            assign w_prev_value       = '0;
            assign w_prev_flags.valid = 1'b1;
            assign w_prev_flags.above = 1'b0;
        end else begin : g_link
            assign w_prev_value = w_value[g-1];
            assign w_prev_flags = w_flags[g-1];
        end

        swmf_sort_cell #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (i_clear),
            .i_insert    (i_insert),
            .i_sample    (i_sample),
            .i_prev_value(w_prev_value),
            .i_prev_flags(w_prev_flags),
            .o_value     (w_value[g]),
            .o_flags     (w_flags[g])
        );
    end

    // Pick the middle element of the sorted window
    assign o_median = w_value[i_mid_idx];

endmodule
